/* rtl/core/load_store_unit_top_defines.svh */
// assertion macros used by the load/store unit back end rtl
`ifndef LOAD_STORE_UNIT_TOP_DEFINES_SVH
`define LOAD_STORE_UNIT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// checked on every clock edge outside reset
`define LSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define LSU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LSU_ASSERT(lbl, prop, msg)
`define LSU_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/core/lsu_pkg.sv */
// shared types, codes and constants of the load/store unit
package lsu_pkg;

	localparam int MEM_BYTES_DEF = 65536;
	localparam int NUM_REGS = 31;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [4:0] ZERO_REG = 5'd31;
	localparam logic [5:0] OFFSET_REG_CODE = 6'd26;

	// completion codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_REG = 2'd1;
	localparam logic [1:0] ST_BAD_MODE = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// addressing mode found by the front end
	typedef enum logic [2:0] {
		MODE_UOFF,
		MODE_WB,
		MODE_ROFF,
		MODE_LIT,
		MODE_BAD
	} mode_t;

	// one classified word as it travels through the queue
	typedef struct packed {
		logic        func;
		mode_t       mode;
		logic        load;
		logic        n8;
		logic        pre;
		logic [4:0]  rt;
		logic [4:0]  xn;
		logic [4:0]  xm;
		logic [11:0] imm12;
		logic [8:0]  simm9;
		logic [18:0] simm19;
		logic [63:0] pc;
		logic [4:0]  reg_index;
		logic [63:0] reg_value;
	} item_t;

	// one finished result
	typedef struct packed {
		logic        done;
		logic [1:0]  status;
		logic        did_load;
		logic [4:0]  target_index;
		logic [63:0] target_value;
		logic        base_written;
		logic [4:0]  base_index;
		logic [63:0] base_value;
		logic [63:0] access_address;
	} res_t;

	// queue fill state seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* rtl/core/load_store_unit_top.sv */
// Load/store unit for single data transfer instructions.
// Input channel: start/busy command style; a word (func, instr, pc,
// reg_index, reg_value) is taken at a clock edge with start high and
// busy low. func 0 executes the transfer instruction, func 1 writes
// reg_value into register reg_index.
// Output channel: done is high for exactly one cycle with the result
// word on status, did_load, target_index, target_value, base_written,
// base_index, base_value and access_address. The receiver cannot stall.
// Words go one at a time through the sequencer: three register file
// read steps, the byte-serial memory port (one byte a cycle) and three
// writeback steps, then a result step that raises done. A faulting
// instruction skips memory and writeback; a register write takes a
// single write step before the result step.
// A two-entry queue behind the front stage lets up to three words be
// taken while one is executing.
// Reset: registers read zero; after reset the byte memory is cleared
// one byte a cycle, all MemBytes bytes, with busy held high meanwhile.
module load_store_unit_top #(
	parameter int MemBytes = lsu_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [31:0] instr,
	input  logic [63:0] pc,
	input  logic [4:0]  reg_index,
	input  logic [63:0] reg_value,
	output logic        done,
	output logic [1:0]  status,
	output logic        did_load,
	output logic [4:0]  target_index,
	output logic [63:0] target_value,
	output logic        base_written,
	output logic [4:0]  base_index,
	output logic [63:0] base_value,
	output logic [63:0] access_address
);
	import lsu_pkg::*;

	logic    front_ready;
	logic    take;
	logic    push;
	logic    pop;
	logic    clearing;
	item_t   f_item;
	item_t   q_item;
	q_stat_t q_stat;
	res_t    res;

	// accept handshake
	assign busy = !front_ready || clearing;
	assign take = start && !busy;

	lsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.func      (func),
		.instr     (instr),
		.pc        (pc),
		.reg_index (reg_index),
		.reg_value (reg_value),
		.q_stat    (q_stat),
		.ready     (front_ready),
		.push      (push),
		.item      (f_item)
	);

	lsu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_item),
		.pop    (pop),
		.dout   (q_item),
		.stat   (q_stat)
	);

	lsu_back #(
		.MemBytes (MemBytes)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_item   (q_item),
		.q_stat   (q_stat),
		.pop      (pop),
		.clearing (clearing),
		.res      (res)
	);

	// result ports
	assign done = res.done;
	assign status = res.status;
	assign did_load = res.did_load;
	assign target_index = res.target_index;
	assign target_value = res.target_value;
	assign base_written = res.base_written;
	assign base_index = res.base_index;
	assign base_value = res.base_value;
	assign access_address = res.access_address;

endmodule

/* rtl/core/lsu_front.sv */
// front end: accepts words and classifies the instruction
module lsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic          func,
	input  logic [31:0]   instr,
	input  logic [63:0]   pc,
	input  logic [4:0]    reg_index,
	input  logic [63:0]   reg_value,
	input  lsu_pkg::q_stat_t q_stat,
	output logic          ready,
	output logic          push,
	output lsu_pkg::item_t item
);
	import lsu_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t dec;

	// decode of the incoming word
	always_comb begin
		dec = '0;
		dec.func = func;
		dec.rt = instr[4:0];
		dec.xn = instr[9:5];
		dec.xm = instr[20:16];
		dec.n8 = instr[30];
		dec.pre = instr[11];
		dec.imm12 = instr[21:10];
		dec.simm9 = instr[20:12];
		dec.simm19 = instr[23:5];
		dec.pc = pc;
		dec.reg_index = reg_index;
		dec.reg_value = reg_value;
		if (instr[31]) begin
			dec.load = instr[22];
			if (instr[24]) begin
				dec.mode = MODE_UOFF;
			end else if (instr[10]) begin
				dec.mode = MODE_WB;
			end else if (instr[15:10] == OFFSET_REG_CODE) begin
				dec.mode = MODE_ROFF;
			end else begin
				dec.mode = MODE_BAD;
			end
		end else begin
			dec.load = 1'b1;
			dec.mode = MODE_LIT;
		end
	end

	assign push = valid_s1 && !q_stat.full;
	assign ready = !valid_s1 || !q_stat.full;
	assign item = item_s1;

	// holding stage in front of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			item_s1 <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
				item_s1 <= dec;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/lsu_queue.sv */
// short queue of classified words between front and back end
module lsu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lsu_pkg::item_t din,
	input  logic          pop,
	output lsu_pkg::item_t dout,
	output lsu_pkg::q_stat_t stat
);
	import lsu_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign stat.full = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign dout = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/lsu_back.sv */
// back end: register file, byte memory and the transfer sequencer
`include "load_store_unit_top_defines.svh"

module lsu_back #(
	parameter int MemBytes = lsu_pkg::MEM_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lsu_pkg::item_t q_item,
	input  lsu_pkg::q_stat_t q_stat,
	output logic           pop,
	output logic           clearing,
	output lsu_pkg::res_t  res
);
	import lsu_pkg::*;

	localparam int AW = $clog2(MemBytes);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RBASE,
		S_RXM,
		S_ADDR,
		S_CHK,
		S_MEM,
		S_WPRE,
		S_WRT,
		S_WPOST,
		S_WREG,
		S_DONE
	} state_t;

	state_t        state_q;
	item_t         cur_q;
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;
	logic [63:0]   base_q;
	logic [63:0]   addr_q;
	logic [63:0]   bval_q;
	logic [63:0]   st_data_q;
	logic [63:0]   ldval_q;
	logic [1:0]    status_q;
	logic [3:0]    cnt_q;
	res_t          res_q;

	// register file with valid bits
	logic [63:0]   rf [NUM_REGS];
	logic [NUM_REGS-1:0] rf_vld_q;
	logic [63:0]   rf_rd_q;
	logic          rf_ok_q;
	logic [4:0]    rf_ra;
	logic          rf_rd_ok;
	logic          rf_we;
	logic [4:0]    rf_wa;
	logic [63:0]   rf_wd;
	logic [63:0]   rdv;

	// byte memory
	logic [7:0]    mem [MemBytes];
	logic [7:0]    mem_rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic [AW-1:0] bidx;

	logic [63:0]   op_a;
	logic [63:0]   op_b;
	logic [63:0]   sum;
	logic [3:0]    n_bytes;
	logic [2:0]    bsel;
	logic          in_range;
	logic          is_wb;
	logic          ok;

	assign is_wb = (cur_q.mode == MODE_WB);
	assign n_bytes = cur_q.n8 ? 4'd8 : 4'd4;
	assign rdv = rf_ok_q ? rf_rd_q : '0;
	assign bidx = addr_q[AW-1:0] + AW'(cnt_q[2:0]);
	assign bsel = cnt_q[2:0] - 3'd1;
	assign in_range = (addr_q < 64'(MemBytes)) && (addr_q <= 64'(MemBytes) - 64'(n_bytes));
	assign ok = (status_q == ST_OK) && !cur_q.func;
	assign pop = (state_q == S_IDLE) && !clr_q && !q_stat.empty;
	assign clearing = clr_q;
	assign res = res_q;

	// register read address per step
	always_comb begin
		case (state_q)
			S_RBASE: rf_ra = cur_q.xn;
			S_RXM:   rf_ra = cur_q.xm;
			S_ADDR:  rf_ra = cur_q.rt;
			default: rf_ra = cur_q.xn;
		endcase
		rf_rd_ok = (rf_ra != ZERO_REG) && rf_vld_q[rf_ra];
	end

	// register write per step, index 31 dropped
	always_comb begin
		rf_we = 1'b0;
		rf_wa = cur_q.xn;
		rf_wd = bval_q;
		case (state_q)
			S_WPRE: begin
				rf_we = is_wb && cur_q.pre && (cur_q.xn != ZERO_REG);
			end
			S_WRT: begin
				rf_we = cur_q.load && (cur_q.rt != ZERO_REG);
				rf_wa = cur_q.rt;
				rf_wd = ldval_q;
			end
			S_WPOST: begin
				rf_we = is_wb && !cur_q.pre && (cur_q.xn != ZERO_REG);
			end
			S_WREG: begin
				rf_we = (cur_q.reg_index != ZERO_REG);
				rf_wa = cur_q.reg_index;
				rf_wd = cur_q.reg_value;
			end
			default: begin
				rf_we = 1'b0;
			end
		endcase
	end

	// shared address adder
	always_comb begin
		op_a = (cur_q.mode == MODE_LIT) ? cur_q.pc : base_q;
		case (cur_q.mode)
			MODE_UOFF: op_b = cur_q.n8 ? 64'({cur_q.imm12, 3'b000}) : 64'({cur_q.imm12, 2'b00});
			MODE_WB:   op_b = {{55{cur_q.simm9[8]}}, cur_q.simm9};
			MODE_ROFF: op_b = rdv;
			MODE_LIT:  op_b = {{43{cur_q.simm19[18]}}, cur_q.simm19, 2'b00};
			default:   op_b = '0;
		endcase
		sum = op_a + op_b;
	end

	// byte memory write port: clearing pass or store
	always_comb begin
		mem_we = clr_q || ((state_q == S_MEM) && !cur_q.load && (cnt_q < n_bytes));
		mem_wa = clr_q ? clr_cnt_q : bidx;
		mem_wd = clr_q ? 8'h00 : st_data_q[{cnt_q[2:0], 3'b000} +: 8];
	end

	// byte memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[bidx];
	end

	// register file storage
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf[rf_wa] <= rf_wd;
		end
		rf_rd_q <= rf[rf_ra];
	end

	// register file valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			rf_ok_q <= 1'b0;
		end else begin
			rf_ok_q <= rf_rd_ok;
			if (rf_we) begin
				rf_vld_q[rf_wa] <= 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= '0;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			base_q <= '0;
			addr_q <= '0;
			bval_q <= '0;
			st_data_q <= '0;
			ldval_q <= '0;
			status_q <= ST_OK;
			cnt_q <= '0;
			res_q <= '0;
		end else begin
			res_q.done <= (state_q == S_DONE);
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == AW'(MemBytes - 1)) begin
					clr_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					status_q <= ST_OK;
					if (pop) begin
						cur_q <= q_item;
						state_q <= q_item.func ? S_WREG : S_RBASE;
					end
				end
				S_RBASE: begin
					state_q <= S_RXM;
				end
				S_RXM: begin
					base_q <= rdv;
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					bval_q <= sum;
					addr_q <= (is_wb && !cur_q.pre) ? base_q : sum;
					if (cur_q.mode == MODE_BAD) begin
						status_q <= ST_BAD_MODE;
					end else if ((cur_q.mode == MODE_ROFF) && (cur_q.xm == ZERO_REG)) begin
						status_q <= ST_BAD_REG;
					end else begin
						status_q <= ST_OK;
					end
					state_q <= S_CHK;
				end
				S_CHK: begin
					st_data_q <= rdv;
					ldval_q <= '0;
					cnt_q <= '0;
					if (status_q != ST_OK) begin
						state_q <= S_DONE;
					end else if (!in_range) begin
						status_q <= ST_RANGE;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MEM;
					end
				end
				S_MEM: begin
					// a read byte is registered and lands in the cycle after its address
					if (cur_q.load && (cnt_q != 4'd0)) begin
						ldval_q[{bsel, 3'b000} +: 8] <= mem_rd_q;
					end
					if (cnt_q == n_bytes) begin
						state_q <= S_WPRE;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_WPRE: begin
					state_q <= S_WRT;
				end
				S_WRT: begin
					state_q <= S_WPOST;
				end
				S_WPOST: begin
					state_q <= S_DONE;
				end
				S_WREG: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					res_q.status <= cur_q.func ? ST_OK : status_q;
					res_q.did_load <= ok && cur_q.load;
					res_q.target_index <= cur_q.func ? 5'd0 : cur_q.rt;
					res_q.target_value <= (ok && cur_q.load) ? ldval_q : '0;
					res_q.base_written <= ok && is_wb;
					res_q.base_index <= cur_q.func ? 5'd0 : cur_q.xn;
					res_q.base_value <= (ok && is_wb) ? bval_q : '0;
					if (cur_q.func || (status_q == ST_BAD_REG) || (status_q == ST_BAD_MODE)) begin
						res_q.access_address <= '0;
					end else begin
						res_q.access_address <= addr_q;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`LSU_ASSERT(a_done_single, res_q.done |=> !res_q.done, "result strobe held over two cycles")
	`LSU_ASSERT(a_no_write_zero_reg, rf_we |-> (rf_wa != ZERO_REG), "write to register 31")
	`LSU_ASSERT_ALWAYS(a_clear_idle, clr_q |-> ((state_q == S_IDLE) && !res_q.done), "work during clear")
	`LSU_ASSERT(a_pop_nonempty, pop |-> !q_stat.empty, "pop from empty queue")

endmodule

/* bench/load_store_unit_top_tb.sv */
// self-checking testbench for the load/store unit: directed and random words against a predictor

// predicted register file and byte memory, with the queue of results still owed by the unit
class lsu_scoreboard;
	logic [63:0] gp_regs [lsu_pkg::NUM_REGS];
	logic [7:0] mem_bytes [lsu_pkg::MEM_BYTES_DEF];
	lsu_pkg::res_t expected_results [$];
	int unsigned mismatches;

	function new();
		foreach (gp_regs[i]) gp_regs[i] = '0;
		foreach (mem_bytes[i]) mem_bytes[i] = '0;
		mismatches = 0;
	endfunction

	// register 31 reads as zero and swallows writes
	function logic [63:0] read_gp(logic [4:0] idx);
		return (idx == lsu_pkg::ZERO_REG) ? 64'd0 : gp_regs[idx];
	endfunction

	function void write_gp(logic [4:0] idx, logic [63:0] val);
		if (idx != lsu_pkg::ZERO_REG) gp_regs[idx] = val;
	endfunction

	// work out the result of one word and apply its side effects
	function lsu_pkg::res_t execute(logic f, logic [31:0] w, logic [63:0] pcv,
			logic [4:0] idx, logic [63:0] val);
		lsu_pkg::res_t r;
		logic [63:0] base, addr, bval, data, mem_size;
		int nbytes;
		logic load, wb, pre;
		r = '0;
		r.done = 1'b1;
		if (f) begin
			write_gp(idx, val);
			return r;
		end
		r.status = lsu_pkg::ST_OK;
		r.target_index = w[4:0];
		r.base_index = w[9:5];
		nbytes = w[30] ? 8 : 4;
		load = 1'b1;
		wb = 1'b0;
		pre = 1'b0;
		addr = '0;
		bval = '0;
		mem_size = 64'(lsu_pkg::MEM_BYTES_DEF);
		// address generation
		if (w[31]) begin
			base = read_gp(w[9:5]);
			load = w[22];
			if (w[24]) begin
				addr = base + (64'(w[21:10]) << (w[30] ? 3 : 2));
			end else if (w[10]) begin
				bval = base + {{55{w[20]}}, w[20:12]};
				wb = 1'b1;
				pre = w[11];
				addr = pre ? bval : base;
			end else if (w[15:10] == lsu_pkg::OFFSET_REG_CODE) begin
				if (w[20:16] == lsu_pkg::ZERO_REG) r.status = lsu_pkg::ST_BAD_REG;
				else addr = base + gp_regs[w[20:16]];
			end else begin
				r.status = lsu_pkg::ST_BAD_MODE;
			end
		end else begin
			addr = pcv + {{43{w[23]}}, w[23:5], 2'b00};
		end
		if (r.status == lsu_pkg::ST_OK && !(addr < mem_size && addr <= mem_size - 64'(nbytes)))
			r.status = lsu_pkg::ST_RANGE;
		// memory access and writebacks, pre-index base first, post-index base last
		if (r.status == lsu_pkg::ST_OK) begin
			if (wb && pre) write_gp(w[9:5], bval);
			if (load) begin
				data = '0;
				for (int i = 0; i < nbytes; i++) data[8*i +: 8] = mem_bytes[int'(addr) + i];
				write_gp(w[4:0], data);
				r.did_load = 1'b1;
				r.target_value = data;
			end else begin
				data = read_gp(w[4:0]);
				for (int i = 0; i < nbytes; i++) mem_bytes[int'(addr) + i] = data[8*i +: 8];
			end
			if (wb && !pre) write_gp(w[9:5], bval);
			r.base_written = wb;
			if (wb) r.base_value = bval;
		end
		if (r.status == lsu_pkg::ST_BAD_REG || r.status == lsu_pkg::ST_BAD_MODE)
			r.access_address = '0;
		else
			r.access_address = addr;
		return r;
	endfunction

	function void note_word(logic f, logic [31:0] w, logic [63:0] pcv,
			logic [4:0] idx, logic [63:0] val);
		expected_results.push_back(execute(f, w, pcv, idx, val));
	endfunction

	function int unsigned outstanding();
		return expected_results.size();
	endfunction

	// one line per mismatch
	task report(string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	task compare_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task check_result(lsu_pkg::res_t got);
		lsu_pkg::res_t want;
		if (expected_results.size() == 0) begin
			report("result word with nothing outstanding");
			return;
		end
		want = expected_results.pop_front();
		compare_field("status", 64'(got.status), 64'(want.status));
		compare_field("did_load", 64'(got.did_load), 64'(want.did_load));
		compare_field("target_index", 64'(got.target_index), 64'(want.target_index));
		compare_field("target_value", got.target_value, want.target_value);
		compare_field("base_written", 64'(got.base_written), 64'(want.base_written));
		compare_field("base_index", 64'(got.base_index), 64'(want.base_index));
		compare_field("base_value", got.base_value, want.base_value);
		compare_field("access_address", got.access_address, want.access_address);
	endtask
endclass

module load_store_unit_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsu_pkg::*;

	localparam int RandomWords = 450;
	localparam int CalmTail = 60;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic func;
	logic [31:0] instr;
	logic [63:0] pc;
	logic [4:0] reg_index;
	logic [63:0] reg_value;
	logic done;
	logic [1:0] status;
	logic did_load;
	logic [4:0] target_index;
	logic [63:0] target_value;
	logic base_written;
	logic [4:0] base_index;
	logic [63:0] base_value;
	logic [63:0] access_address;

	lsu_scoreboard sb = new();
	int unsigned words_sent = 0;

	load_store_unit_top #(.MemBytes(MEM_BYTES_DEF)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.instr(instr),
		.pc(pc),
		.reg_index(reg_index),
		.reg_value(reg_value),
		.done(done),
		.status(status),
		.did_load(did_load),
		.target_index(target_index),
		.target_value(target_value),
		.base_written(base_written),
		.base_index(base_index),
		.base_value(base_value),
		.access_address(access_address)
	);

	always #1 clk = ~clk;

	// result words are taken on every strobe
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{1'b1, status, did_load, target_index, target_value,
				base_written, base_index, base_value, access_address});
	end

	// build an instruction word; bits the mode leaves free stay random
	function automatic logic [31:0] encode(mode_t m, logic pre, logic load, logic n8,
			logic [4:0] rt, logic [4:0] xn, logic [18:0] imm);
		logic [31:0] w;
		w = $urandom;
		w[4:0] = rt;
		w[30] = n8;
		if (m == MODE_LIT) begin
			w[31] = 1'b0;
			w[23:5] = imm;
		end else begin
			w[31] = 1'b1;
			w[22] = load;
			w[9:5] = xn;
			case (m)
				MODE_UOFF: begin
					w[24] = 1'b1;
					w[21:10] = imm[11:0];
				end
				MODE_WB: begin
					w[24] = 1'b0;
					w[20:12] = imm[8:0];
					w[11] = pre;
					w[10] = 1'b1;
				end
				MODE_ROFF: begin
					w[24] = 1'b0;
					w[20:16] = imm[4:0];
					w[15:10] = OFFSET_REG_CODE;
				end
				default: begin
					w[24] = 1'b0;
					w[10] = 1'b0;
					if (w[15:10] == OFFSET_REG_CODE) w[12] = 1'b1;
				end
			endcase
		end
		return w;
	endfunction

	// present one word and hold it until taken; start stays high on return
	task automatic send_word(logic f, logic [31:0] w, logic [63:0] pcv,
			logic [4:0] idx, logic [63:0] val);
		start <= 1'b1;
		func <= f;
		instr <= w;
		pc <= pcv;
		reg_index <= idx;
		reg_value <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_word(f, w, pcv, idx, val);
		words_sent++;
	endtask

	task automatic write_word(logic [4:0] idx, logic [63:0] val);
		send_word(1'b1, $urandom, {$urandom, $urandom}, idx, val);
	endtask

	task automatic access_word(mode_t m, logic pre, logic load, logic n8, logic [4:0] rt,
			logic [4:0] xn, logic [18:0] imm, logic [63:0] pcv);
		send_word(1'b0, encode(m, pre, load, n8, rt, xn, imm), pcv,
			5'($urandom_range(0, 30)), {$urandom, $urandom});
	endtask

	task automatic idle(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off until every outstanding result word is back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	task automatic maybe_gap(bit gaps_on);
		if (gaps_on && $urandom_range(0, 2) == 0) idle($urandom_range(1, 13));
	endtask

	// mostly low memory, now and then just below the top edge
	function automatic logic [63:0] pick_addr();
		if ($urandom_range(0, 9) == 0) return 64'(MEM_BYTES_DEF - $urandom_range(1, 40));
		return 64'($urandom_range(0, 511));
	endfunction

	// set up a base and run a few accesses through it
	task automatic access_burst(bit gaps_on);
		logic [4:0] xn, rt, xm;
		logic [18:0] imm;
		mode_t m;
		logic load, n8;
		xn = ($urandom_range(0, 19) == 0) ? ZERO_REG : 5'($urandom_range(0, 30));
		if (xn != ZERO_REG) begin
			write_word(xn, pick_addr());
			maybe_gap(gaps_on);
		end
		repeat ($urandom_range(1, 4)) begin
			load = 1'($urandom_range(0, 1));
			n8 = 1'($urandom_range(0, 1));
			rt = 5'($urandom_range(0, 31));
			imm = 19'($urandom);
			case ($urandom_range(0, 3))
				0: m = MODE_UOFF;
				1: m = MODE_ROFF;
				default: m = MODE_WB;
			endcase
			if (!load && rt != xn && rt != ZERO_REG && $urandom_range(0, 1)) begin
				write_word(rt, {$urandom, $urandom});
				maybe_gap(gaps_on);
			end
			if (m == MODE_UOFF && $urandom_range(0, 7) != 0)
				imm = 19'($urandom_range(0, 31));
			if (m == MODE_ROFF) begin
				if ($urandom_range(0, 7) == 0) begin
					xm = ZERO_REG;
				end else begin
					do xm = 5'($urandom_range(0, 30)); while (xm == xn);
					write_word(xm, 64'($urandom_range(0, 255)) - 64'd64);
					maybe_gap(gaps_on);
				end
				imm = 19'(xm);
			end
			access_word(m, 1'($urandom_range(0, 1)), load, n8, rt, xn, imm,
				{$urandom, $urandom});
			maybe_gap(gaps_on);
		end
	endtask

	// literal load near a random pc, sometimes from anywhere
	task automatic literal_load(bit gaps_on);
		logic [63:0] pcv;
		logic [18:0] imm;
		if ($urandom_range(0, 3) == 0) begin
			pcv = {$urandom, $urandom};
			imm = 19'($urandom);
		end else begin
			pcv = pick_addr();
			imm = 19'($urandom_range(0, 128)) - 19'd64;
		end
		access_word(MODE_LIT, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
			5'($urandom_range(0, 31)), imm, pcv);
		maybe_gap(gaps_on);
	endtask

	initial begin
		bit gaps_on;
		bit paused;
		int unsigned last_word;
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= 1'b0;
		instr <= '0;
		pc <= '0;
		reg_index <= '0;
		reg_value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words: field extremes, every mode and the corner cases
		write_word(5'd1, 64'h100);
		write_word(5'd2, 64'hffee_ddcc_bbaa_9988);
		access_word(MODE_UOFF, 1'b0, 1'b0, 1'b1, 5'd2, 5'd1, 19'd0, '0);
		access_word(MODE_UOFF, 1'b0, 1'b1, 1'b0, 5'd3, 5'd1, 19'd0, '0);
		access_word(MODE_UOFF, 1'b0, 1'b1, 1'b1, 5'd4, 5'd1, 19'hfff, '0);
		// rt equal to base with pre- then post-indexing
		write_word(5'd6, 64'h108);
		access_word(MODE_WB, 1'b1, 1'b1, 1'b1, 5'd6, 5'd6, 19'h1f8, '0);
		write_word(5'd7, 64'h100);
		access_word(MODE_WB, 1'b0, 1'b1, 1'b1, 5'd7, 5'd7, 19'h0ff, '0);
		access_word(MODE_WB, 1'b1, 1'b0, 1'b0, 5'd2, 5'd7, 19'h100, '0);
		// offset register 31, then a good register offset
		access_word(MODE_ROFF, 1'b0, 1'b1, 1'b1, 5'd9, 5'd1, 19'(ZERO_REG), '0);
		write_word(5'd8, 64'd8);
		access_word(MODE_ROFF, 1'b0, 1'b1, 1'b1, 5'd9, 5'd1, 19'd8, '0);
		access_word(MODE_BAD, 1'b0, 1'b1, 1'b1, 5'd9, 5'd1, 19'd0, '0);
		// top of memory: out of range leaves the base alone
		write_word(5'd10, 64'(MEM_BYTES_DEF - 4));
		access_word(MODE_UOFF, 1'b0, 1'b1, 1'b1, 5'd11, 5'd10, 19'd0, '0);
		access_word(MODE_UOFF, 1'b0, 1'b0, 1'b0, 5'd2, 5'd10, 19'd0, '0);
		access_word(MODE_WB, 1'b1, 1'b1, 1'b1, 5'd11, 5'd10, 19'd4, '0);
		// literal loads, wrapping both ways
		access_word(MODE_LIT, 1'b0, 1'b1, 1'b1, 5'd12, 5'd0, 19'd1, 64'hfc);
		access_word(MODE_LIT, 1'b0, 1'b1, 1'b1, 5'd12, 5'd0, 19'h7ffff, 64'd0);
		access_word(MODE_LIT, 1'b0, 1'b1, 1'b0, 5'd12, 5'd0, 19'd2, 64'hffff_ffff_ffff_fffc);
		access_word(MODE_LIT, 1'b0, 1'b1, 1'b0, 5'd12, 5'd0, 19'h3ffff, 64'd0);
		// register 31 as base, store source and load target
		access_word(MODE_UOFF, 1'b0, 1'b0, 1'b1, ZERO_REG, ZERO_REG, 19'd2, '0);
		access_word(MODE_UOFF, 1'b0, 1'b1, 1'b1, ZERO_REG, 5'd1, 19'd0, '0);
		write_word(ZERO_REG, '1);
		access_word(MODE_WB, 1'b1, 1'b1, 1'b1, 5'd13, ZERO_REG, 19'd8, '0);
		drain();

		// random part: mostly well-formed bursts, also literal loads, register writes and noise
		last_word = words_sent + RandomWords;
		paused = 1'b0;
		while (words_sent < last_word) begin
			gaps_on = (last_word - words_sent > CalmTail) && $urandom_range(0, 1);
			if (!paused && last_word - words_sent < RandomWords / 2) begin
				drain();
				paused = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: access_burst(gaps_on);
				6, 7: literal_load(gaps_on);
				8: begin
					write_word(5'($urandom_range(0, 30)), {$urandom, $urandom});
					maybe_gap(gaps_on);
				end
				default: begin
					send_word(1'b0, $urandom, {$urandom, $urandom}, 5'($urandom_range(0, 30)),
						{$urandom, $urandom});
					maybe_gap(gaps_on);
				end
			endcase
		end
		start <= 1'b0;

		// let the last words come back, then allow for stragglers
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// covers the memory clear after reset and the slowest legal run several times over
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
